// File: rtl/chacha20_stream_cipher_top_assert.svh
// assertion macros for the stream cipher checker
`ifndef CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CC_ASSERT_RESET(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/cc_pkg.sv
`default_nettype none
package cc_pkg;
	localparam int unsigned NumWords = 16;
	localparam int unsigned NumCells = 4;
	localparam int unsigned NumRounds = 20;
	localparam int unsigned BufWords = 8;
	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646E;
	localparam logic [31:0] Sigma2 = 32'h79622D32;
	localparam logic [31:0] Sigma3 = 32'h6B206574;
	localparam logic [2:0] RegKey0 = 3'd0;
	localparam logic [2:0] RegKey1 = 3'd1;
	localparam logic [2:0] RegKey2 = 3'd2;
	localparam logic [2:0] RegKey3 = 3'd3;
	localparam logic [2:0] RegCtr = 3'd4;
	localparam logic [2:0] RegNonce = 3'd5;

	typedef logic [31:0] word_t;
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} column_t;

	function automatic word_t rotl(input word_t x, input int unsigned s);
		rotl = (x << s) | (x >> (32 - s));
	endfunction

	function automatic column_t quarter(input column_t q);
		column_t r;
		r = q;
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
		quarter = r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/chacha20_stream_cipher_top.sv
`default_nettype none
// mid block, the output word is registered the cycle after its item is taken;
// an item that opens a keystream block waits for the core: load, the 20 rounds
// through the four-lane quarter-round row and handover; no item is taken meanwhile
// items within a block follow back to back, one per cycle unless the output stalls
// reset (arst_n low): counter, word position and handshakes cleared; keys zero
module chacha20_stream_cipher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // data_word[63:0], byte_count[67:64], zero pad
	input  wire logic        s_tuser,  // msg_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata   // out_word[63:0], out_count[67:64], zero pad
);
	logic [63:0] key0_q, key1_q, key2_q, key3_q, ctr_start_q, nonce_q, ctr_q;
	logic [2:0] pos_q;
	logic [63:0] buf_q [cc_pkg::BufWords];
	logic wait_q;
	logic [63:0] data_q;
	logic [3:0] cnt_q;
	logic [511:0] init_state, ks_block;
	logic core_done, start, acc, emit;
	logic [63:0] ctr_use;
	logic [3:0] cnt_sat;
	logic [63:0] mask;
	logic [63:0] out_word_q;
	logic [3:0] out_cnt_q;

	function automatic logic [63:0] mask_in(input logic [3:0] c);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) m[8*i +: 8] = (4'(i) < c) ? 8'hFF : 8'h00;
		mask_in = m;
	endfunction

	assign cnt_sat = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
	assign s_tready = !wait_q && (!m_tvalid || m_tready);
	assign acc = s_tvalid && s_tready;
	assign ctr_use = s_tuser ? ctr_start_q : ctr_q;
	assign start = acc && (s_tuser || pos_q == 3'd0);
	assign emit = core_done || (acc && !start);
	assign init_state = {nonce_q, ctr_use, key3_q, key2_q, key1_q, key0_q,
		cc_pkg::Sigma3, cc_pkg::Sigma2, cc_pkg::Sigma1, cc_pkg::Sigma0};

	cc_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .init_state(init_state),
		.done(core_done), .ks_block(ks_block)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			ctr_start_q <= '0; nonce_q <= '0; ctr_q <= '0;
			pos_q <= '0; wait_q <= 1'b0; m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cc_pkg::RegKey0: key0_q <= cfg_data;
					cc_pkg::RegKey1: key1_q <= cfg_data;
					cc_pkg::RegKey2: key2_q <= cfg_data;
					cc_pkg::RegKey3: key3_q <= cfg_data;
					cc_pkg::RegCtr: ctr_start_q <= cfg_data;
					cc_pkg::RegNonce: nonce_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (acc) begin
				if (start) begin
					ctr_q <= ctr_use + 64'd1;
					wait_q <= 1'b1;
					pos_q <= 3'd1;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
			if (core_done) begin
				wait_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			for (int i = 0; i < cc_pkg::BufWords; i++) buf_q[i] <= ks_block[64*i +: 64];
		end
		if (acc) begin
			data_q <= s_tdata[63:0];
			cnt_q <= cnt_sat;
		end
	end

	always_comb begin
		mask = '0;
		for (int i = 0; i < 8; i++) mask[8*i +: 8] = (4'(i) < cnt_q) ? 8'hFF : 8'h00;
	end

	// output: pending item ^ fresh block word 0, or new item ^ buffered word
	always_ff @(posedge clk) begin
		if (core_done) begin
			out_word_q <= (data_q ^ ks_block[63:0]) & mask;
			out_cnt_q <= cnt_q;
		end else if (acc && !start) begin
			out_word_q <= (s_tdata[63:0] ^ buf_q[pos_q]) & mask_in(cnt_sat);
			out_cnt_q <= cnt_sat;
		end
	end

	assign m_tdata = {4'd0, out_cnt_q, out_word_q};
endmodule
`default_nettype wire

// File: rtl/cc_cell.sv
`default_nettype none
// one quarter-round lane; holds one column or diagonal of the state
module cc_cell (
	input  wire logic            clk,
	input  wire logic            load,
	input  wire logic            step,
	input  wire cc_pkg::column_t init,
	input  wire cc_pkg::column_t from_nbr,
	output cc_pkg::column_t      col_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			col_q <= init;
		end else if (step) begin
			col_q <= cc_pkg::quarter(from_nbr);
		end
	end
endmodule
`default_nettype wire

// File: rtl/cc_core.sv
`default_nettype none
// row of four lanes; after the first round, lanes trade words each round for the column/diagonal switch
module cc_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [511:0]        init_state,
	output logic                     done,
	output logic [511:0]             ks_block
);
	localparam int unsigned CntW = $clog2(cc_pkg::NumRounds + 1);
	cc_pkg::column_t col [cc_pkg::NumCells];
	cc_pkg::column_t nbr [cc_pkg::NumCells];
	cc_pkg::column_t ini [cc_pkg::NumCells];
	logic [CntW-1:0] round_q;
	logic [511:0] init_q;
	logic busy_q, done_q;
	logic odd;

	assign odd = round_q[0];
	assign done = done_q;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ini[i].a = init_state[32*i +: 32];
			ini[i].b = init_state[32*(4+i) +: 32];
			ini[i].c = init_state[32*(8+i) +: 32];
			ini[i].d = init_state[32*(12+i) +: 32];
		end
		// round 0: columns as held, odd round: diagonals from neighbours, later even round: columns back from neighbours
		for (int i = 0; i < 4; i++) begin
			nbr[i].a = col[i].a;
			nbr[i].b = odd ? col[(i+1)%4].b : col[(i+3)%4].b;
			nbr[i].c = odd ? col[(i+2)%4].c : col[(i+2)%4].c;
			nbr[i].d = odd ? col[(i+3)%4].d : col[(i+1)%4].d;
		end
		if (round_q == CntW'(0)) begin
			for (int i = 0; i < 4; i++) nbr[i] = col[i];
		end
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_cell
			cc_cell u_cell (
				.clk(clk), .load(start), .step(busy_q),
				.init(ini[g]), .from_nbr(nbr[g]), .col_q(col[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				round_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				round_q <= round_q + CntW'(1);
				if (round_q == CntW'(cc_pkg::NumRounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) init_q <= init_state;
	end

	// the last round is a diagonal round, so lanes still hold diagonals
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ks_block[32*i +: 32] = col[i].a + init_q[32*i +: 32];
			ks_block[32*(4+i) +: 32] = col[(i+3)%4].b + init_q[32*(4+i) +: 32];
			ks_block[32*(8+i) +: 32] = col[(i+2)%4].c + init_q[32*(8+i) +: 32];
			ks_block[32*(12+i) +: 32] = col[(i+1)%4].d + init_q[32*(12+i) +: 32];
		end
	end
endmodule
`default_nettype wire

// File: rtl/cc_checker.sv
`default_nettype none
`include "chacha20_stream_cipher_top_assert.svh"
module cc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [71:0] m_tdata
);
	`CC_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[71:68] == 4'd0, "pad not zero")
	`CC_ASSERT_IMPL(a_cnt_max, clk, arst_n, m_tvalid |-> m_tdata[67:64] <= 4'd8, "count above eight")
	`CC_ASSERT_IMPL(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata), "stalled output changed")
	`CC_ASSERT_IMPL(a_in_block, clk, arst_n,
		(m_tvalid && !m_tready) |-> !s_tready, "input ready while output stalled")
	`CC_ASSERT_RESET(a_rst, clk, arst_n, !arst_n |-> !m_tvalid, "valid in reset")
endmodule
bind chacha20_stream_cipher_top cc_checker u_cc_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // data_word[63:0], byte_count[67:64], zero pad
	logic        s_tuser;  // msg_start
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // out_word[63:0], out_count[67:64], zero pad

	chacha20_stream_cipher_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [3:0]  cnt;
		logic [63:0] word;
	} cipher_out_t;

	// predictor state
	logic [63:0] key_reg [4];
	logic [63:0] ctr_start_reg;
	logic [63:0] nonce_reg;
	logic [63:0] blk_ctr;
	logic [63:0] ks_words [8];
	logic [2:0]  ks_pos;

	cipher_out_t cipher_q[$];
	int          errors;
	int          idle_cycles;
	bit          draining;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rol32(logic [31:0] x, int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic qround(inout logic [31:0] w [16], input int a, b, c, d);
		w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
		w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
		w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
		w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
	endtask

	task automatic gen_keystream_block();
		logic [31:0] init [16];
		logic [31:0] w [16];
		logic [63:0] src [6];
		src[0] = key_reg[0]; src[1] = key_reg[1]; src[2] = key_reg[2];
		src[3] = key_reg[3]; src[4] = blk_ctr; src[5] = nonce_reg;
		init[0] = cc_pkg::Sigma0; init[1] = cc_pkg::Sigma1;
		init[2] = cc_pkg::Sigma2; init[3] = cc_pkg::Sigma3;
		for (int i = 0; i < 6; i++) begin
			init[4 + 2 * i] = src[i][31:0];
			init[5 + 2 * i] = src[i][63:32];
		end
		w = init;
		for (int r = 0; r < 10; r++) begin
			qround(w, 0, 4, 8, 12); qround(w, 1, 5, 9, 13);
			qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
			qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
			qround(w, 2, 7, 8, 13); qround(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 8; i++)
			ks_words[i] = {w[2 * i + 1] + init[2 * i + 1], w[2 * i] + init[2 * i]};
		blk_ctr = blk_ctr + 64'd1;
	endtask

	task automatic predict_cipher(input logic [63:0] data, input logic [3:0] cnt_in,
			input logic start, output cipher_out_t res);
		logic [3:0]  cnt;
		logic [63:0] mask;
		logic [63:0] ks;
		cnt = (cnt_in > 4'd8) ? 4'd8 : cnt_in;
		if (start) begin
			blk_ctr = ctr_start_reg;
			ks_pos = 3'd0;
		end
		if (ks_pos == 3'd0)
			gen_keystream_block();
		ks = ks_words[ks_pos];
		ks_pos = ks_pos + 3'd1;
		mask = (cnt == 4'd8) ? '1 : ((64'd1 << (8 * cnt)) - 64'd1);
		res.word = (data ^ ks) & mask;
		res.cnt = cnt;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cc_pkg::RegKey0: key_reg[0] = val;
			cc_pkg::RegKey1: key_reg[1] = val;
			cc_pkg::RegKey2: key_reg[2] = val;
			cc_pkg::RegKey3: key_reg[3] = val;
			cc_pkg::RegCtr: ctr_start_reg = val;
			cc_pkg::RegNonce: nonce_reg = val;
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [63:0] data, input logic [3:0] cnt, input logic start);
		cipher_out_t res;
		s_tdata <= {4'd0, cnt, data};
		s_tuser <= start;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_cipher(data, cnt, start, res);
		cipher_q.push_back(res);
		@(negedge clk);
	endtask

	// bursts of random length, gaps between them
	int burst_left;
	task automatic send_paced(input logic [63:0] data, input logic [3:0] cnt, input logic start);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_item(data, cnt, start);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// receiver stall pattern
	int stall_mode;
	always @(negedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	always @(posedge clk) begin
		cipher_out_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[67:0];
			if (cipher_q.size() == 0) begin
				$error("unexpected transfer out_word=%h", got.word);
				errors++;
			end else begin
				exp = cipher_q.pop_front();
				if (got.word !== exp.word) begin
					$error("out_word expected %h actual %h", exp.word, got.word);
					errors++;
				end
				if (got.cnt !== exp.cnt) begin
					$error("out_count expected %0d actual %0d", exp.cnt, got.cnt);
					errors++;
				end
				if (m_tdata[71:68] !== 4'd0) begin
					$error("pad expected 0 actual %h", m_tdata[71:68]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || draining)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	typedef struct {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        start;
		bit          known;
		logic [63:0] exp_word;
	} stim_row_t;

	stim_row_t dir_rows [$];

	initial begin
		int n_items;
		logic [63:0] d;
		errors = 0;
		draining = 0;
		burst_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		key_reg[0] = '0; key_reg[1] = '0; key_reg[2] = '0; key_reg[3] = '0;
		ctr_start_reg = '0; nonce_reg = '0;
		blk_ctr = '0; ks_pos = '0;
		for (int i = 0; i < 8; i++) ks_words[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero key, counter zero; zero data gives raw keystream
		// (block 0 of the all-zero key/nonce starts 76b8e0ada0f13d90)
		dir_rows.push_back('{64'h0, 4'd8, 1'b1, 1'b1, 64'h903df1a0ade0b876});
		dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1, 64'h0});
		dir_rows.push_back('{64'h0123_4567_89AB_CDEF, 4'd1, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'h5A5A_5A5A_5A5A_5A5A, 4'd7, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'h0, 4'd3, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'h0, 4'd8, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'hDEAD_BEEF_CAFE_F00D, 4'd4, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'h0, 4'd8, 1'b1, 1'b1, 64'h903df1a0ade0b876});
		dir_rows.push_back('{64'h1122_3344_5566_7788, 4'd2, 1'b1, 1'b0, 64'h0});
		dir_rows.push_back('{64'h0, 4'd5, 1'b0, 1'b0, 64'h0});
		dir_rows.push_back('{64'h0, 4'd6, 1'b0, 1'b0, 64'h0});
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].data, dir_rows[i].cnt, dir_rows[i].start);
			if (dir_rows[i].known && cipher_q[$].word !== dir_rows[i].exp_word) begin
				$error("out_word expected %h predicted %h", dir_rows[i].exp_word,
					cipher_q[$].word);
				errors++;
			end
		end
		wait_idle();

		// counter wrap and all-ones registers
		for (int r = 0; r < 6; r++) write_reg(r[2:0], '1);
		write_reg(cc_pkg::RegCtr, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 20; i++) send_item(rand64(), 4'($urandom_range(0, 15)), i == 0);
		wait_idle();
		write_reg(3'd6, rand64());
		write_reg(3'd7, rand64());

		n_items = 0;
		for (int ph = 0; ph < 6; ph++) begin
			stall_mode = ph % 4;
			for (int r = 0; r < 6; r++)
				write_reg(r[2:0], (ph == 1) ? 64'h0 : rand64());
			if (ph == 2) write_reg(cc_pkg::RegCtr, 64'hFFFF_FFFF_FFFF_FFFE);
			while (n_items < (ph + 1) * 215) begin
				int len;
				len = $urandom_range(1, 30);
				for (int k = 0; k < len; k++) begin
					d = rand64();
					if ($urandom_range(0, 9) == 0)
						send_paced(d, 4'($urandom_range(0, 15)), k == 0);
					else if (k == len - 1)
						send_paced(d, 4'($urandom_range(1, 8)), k == 0);
					else
						send_paced(d, 4'd8, k == 0);
					n_items++;
				end
			end
			wait_idle();
		end

		draining = 1;
		s_tvalid <= 1'b0;
		repeat (50) @(negedge clk);
		if (cipher_q.size() != 0) begin
			$error("%0d results missing", cipher_q.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: chacha20_stream_cipher_top.f
+incdir+rtl
rtl/cc_pkg.sv
rtl/cc_cell.sv
rtl/cc_core.sv
rtl/chacha20_stream_cipher_top.sv
rtl/cc_checker.sv
tb/tb.sv
